### src/ffpa_pkg.sv
// Shared types and constants for the first-fit pool allocator.
`timescale 1ns / 1ps
package ffpa_pkg;

    // Offset width fixed by the payload fields.
    localparam int OFS_BITS = 16;
    // Width of a block end: start + header + payload length.
    localparam int END_BITS = OFS_BITS + 2;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_FORMAT  = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_ROOM   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_REL,
        ST_DONE
    } fsm_t;

    // One table entry: header offset and payload length of a block.
    typedef struct packed {
        logic [OFS_BITS-1:0] start;
        logic [OFS_BITS-1:0] len;
    } entry_t;

endpackage

### src/ffpa_if.sv
// Handshake channels of the allocator: request, response and configuration write.
`timescale 1ns / 1ps
interface ffpa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] request_size;
    logic [15:0] release_offset;

    modport source (output valid, operation, request_size, release_offset, input ready);
    modport sink   (input valid, operation, request_size, release_offset, output ready);
endinterface

interface ffpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] block_offset;
    logic [15:0] bytes_in_use;

    modport source (output valid, status, block_offset, bytes_in_use, input ready);
    modport sink   (input valid, status, block_offset, bytes_in_use, output ready);
endinterface

interface ffpa_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### src/ffpa_cell.sv
// One table slot of the block chain; takes its neighbor's entry on each shift.
`timescale 1ns / 1ps
module ffpa_cell
    import ffpa_pkg::*;
(
    input  logic   clk,
    input  logic   shift,
    input  entry_t data_in,
    output entry_t data_out
);

    entry_t data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= data_in;
        end
    end

    assign data_out = data_reg;

endmodule

### src/first_fit_pool_allocator_unit.sv
// Top level of the first-fit pool allocator: control, usage counter and block chain.
//
//  channel | dir | beat
//  --------+-----+-------------------------------------------------------
//  req     | in  | operation, request_size, release_offset
//  rsp     | out | status, block_offset, bytes_in_use
//  cfg     | in  | data -> pool_size
//
// Allocate rotates the whole chain once between accept and result.
// Release rotates it once plus one slot, since hold lags the head by one slot.
// Format, unused codes and early rejects skip the chain. rsp is a register, so a new
// beat is taken while a result waits; a finished result holds until rsp drains.
// Reset empties the table (block count zero) and restores pool_size to 4096.
`timescale 1ns / 1ps
module first_fit_pool_allocator_unit
    import ffpa_pkg::*;
#(
    parameter int MAX_BLOCKS   = 16,
    parameter int HEADER_BYTES = 24,
    parameter int INFO_BYTES   = 16
)
(
    input  logic clk,
    input  logic rst_n,
    ffpa_req_if.sink   req,
    ffpa_rsp_if.source rsp,
    ffpa_cfg_if.sink   cfg
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
    localparam logic [END_BITS-1:0] ROOT_END = END_BITS'(HEADER_BYTES + INFO_BYTES);
    localparam logic [END_BITS-1:0] HDR = END_BITS'(HEADER_BYTES);

    fsm_t state_reg, state_next;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [OFS_BITS-1:0] usage_reg, usage_next;
    logic [OFS_BITS-1:0] pool_reg;
    logic                found_reg, found_next;
    logic [END_BITS-1:0] prev_end_reg, prev_end_next;
    logic [END_BITS-1:0] size_reg, size_next;
    logic [OFS_BITS-1:0] size_req_reg, size_req_next;
    logic [OFS_BITS-1:0] ofs_reg, ofs_next;
    entry_t              hold_reg;
    status_t             res_status_reg, res_status_next;
    logic [OFS_BITS-1:0] res_offset_reg, res_offset_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_status_reg;
    logic [OFS_BITS-1:0] out_offset_reg, out_usage_reg;

    logic   accept, shift, last_alloc, last_rel, drain_ok;
    entry_t head, feed;
    entry_t chain [MAX_BLOCKS];

    // Block chain: slot 0 is read, the last slot takes the feed.
    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        entry_t cell_in;
        if (i == MAX_BLOCKS - 1)
        begin : g_tail
            assign cell_in = feed;
        end
        else
        begin : g_mid
            assign cell_in = chain[i+1];
        end
        ffpa_cell u_cell (
            .clk      (clk),
            .shift    (shift),
            .data_in  (cell_in),
            .data_out (chain[i])
        );
    end

    assign head       = chain[0];
    assign accept     = req.valid && req.ready;
    assign last_alloc = (step_reg == CNT_W'(MAX_BLOCKS - 1));
    assign last_rel   = (step_reg == CNT_MAX);
    assign drain_ok   = !out_valid_reg || rsp.ready;
    assign cfg.ready  = 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op_t'(req.operation) == OP_RELEASE)
                        state_next = ST_REL;
                    else if (op_t'(req.operation) == OP_ALLOC &&
                             ({1'b0, pool_reg} >= {1'b0, usage_reg} + {1'b0, req.request_size})
                             && count_reg != CNT_MAX)
                        state_next = ST_ALLOC;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_ALLOC: if (last_alloc) state_next = ST_DONE;
            ST_REL:   if (last_rel) state_next = ST_DONE;
            ST_DONE:  if (drain_ok) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        req.ready = 1'b0;
        shift     = 1'b0;
        unique case (state_reg)
            ST_IDLE:  req.ready = 1'b1;
            ST_ALLOC: shift = 1'b1;
            ST_REL:   shift = 1'b1;
            ST_DONE:  ;
            default:  ;
        endcase
    end

    // Datapath
    always_comb
    begin
        logic [OFS_BITS:0]   need;
        logic [END_BITS-1:0] start_x, gap, tail_gap, hold_end;
        logic                hit;
        logic [END_BITS-1:0] sz;

        step_next       = step_reg;
        count_next      = count_reg;
        usage_next      = usage_reg;
        found_next      = found_reg;
        prev_end_next   = prev_end_reg;
        size_next       = size_reg;
        size_req_next   = size_req_reg;
        ofs_next        = ofs_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        feed            = head;
        hit             = 1'b0;

        need     = (OFS_BITS+1)'(HEADER_BYTES) + {1'b0, size_req_reg};
        start_x  = END_BITS'(head.start);
        gap      = (start_x > prev_end_reg) ? start_x - prev_end_reg : '0;
        tail_gap = (END_BITS'(pool_reg) > prev_end_reg) ?
                   END_BITS'(pool_reg) - prev_end_reg : '0;
        hold_end = END_BITS'(hold_reg.start) + HDR;
        sz       = size_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    step_next       = '0;
                    found_next      = 1'b0;
                    prev_end_next   = ROOT_END;
                    size_req_next   = req.request_size;
                    ofs_next        = req.release_offset;
                    res_offset_next = '0;
                    res_status_next = STAT_OK;
                    case (req.operation)
                        OP_ALLOC:
                        begin
                            if ({1'b0, pool_reg} < {1'b0, usage_reg} + {1'b0, req.request_size})
                                res_status_next = STAT_NO_ROOM;
                            else if (count_reg == CNT_MAX)
                                res_status_next = STAT_FULL;
                        end
                        OP_FORMAT:
                        begin
                            count_next = '0;
                            usage_next = ROOT_END[OFS_BITS-1:0];
                        end
                        default: ;
                    endcase
                end
            end
            ST_ALLOC:
            begin
                step_next = step_reg + 1'b1;
                if (found_reg)
                begin
                    feed = hold_reg;
                end
                else if ((step_reg < count_reg && END_BITS'(need) <= gap) ||
                         (step_reg == count_reg && END_BITS'(need) <= tail_gap))
                begin
                    hit             = 1'b1;
                    found_next      = 1'b1;
                    feed.start      = prev_end_reg[OFS_BITS-1:0];
                    feed.len        = size_req_reg;
                    res_offset_next = OFS_BITS'(prev_end_reg + HDR);
                end
                else if (step_reg < count_reg)
                begin
                    prev_end_next = start_x + HDR + END_BITS'(head.len);
                end
                if (last_alloc)
                begin
                    if (found_reg || hit)
                    begin
                        res_status_next = STAT_OK;
                        count_next      = count_reg + 1'b1;
                        usage_next      = usage_reg + need[OFS_BITS-1:0];
                    end
                    else
                    begin
                        res_status_next = STAT_NO_ROOM;
                        res_offset_next = '0;
                    end
                end
            end
            ST_REL:
            begin
                // hold lags the head by one slot, so the removed entry is skipped
                step_next = step_reg + 1'b1;
                if (!found_reg && step_reg != '0 && step_reg <= count_reg &&
                    hold_end == END_BITS'(ofs_reg))
                begin
                    hit        = 1'b1;
                    found_next = 1'b1;
                    sz         = HDR + END_BITS'(hold_reg.len);
                    size_next  = sz;
                end
                feed = (found_reg || hit) ? head : hold_reg;
                if (last_rel)
                begin
                    if (found_reg || hit)
                    begin
                        res_status_next = STAT_OK;
                        count_next      = count_reg - 1'b1;
                        usage_next      = (END_BITS'(usage_reg) > sz) ?
                                          OFS_BITS'(END_BITS'(usage_reg) - sz) : '0;
                    end
                    else
                    begin
                        res_status_next = STAT_NOT_FOUND;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == ST_DONE && drain_ok)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            usage_reg     <= ROOT_END[OFS_BITS-1:0];
            pool_reg      <= 16'd4096;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            usage_reg     <= usage_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            step_reg      <= step_next;
            if (cfg.valid)
                pool_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_end_reg   <= prev_end_next;
        size_reg       <= size_next;
        size_req_reg   <= size_req_next;
        ofs_reg        <= ofs_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        if (shift)
            hold_reg <= head;
        if (state_reg == ST_DONE && drain_ok)
        begin
            out_status_reg <= res_status_reg;
            out_offset_reg <= res_offset_reg;
            out_usage_reg  <= usage_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.block_offset = out_offset_reg;
    assign rsp.bytes_in_use = out_usage_reg;

endmodule

### tb/first_fit_pool_allocator_unit_checker.sv
// Checker for the first-fit pool allocator: tracks the block table and compares each response.
`timescale 1ns / 1ps
module first_fit_pool_allocator_unit_checker
    import ffpa_pkg::*;
#(
    parameter int MAX_BLOCKS   = 16,
    parameter int HEADER_BYTES = 24,
    parameter int INFO_BYTES   = 16
)
(
    input  logic clk,
    input  logic rst_n,
    ffpa_req_if req,
    ffpa_rsp_if rsp,
    ffpa_cfg_if cfg,
    output int   fail_count,
    output int   pending,
    output int   rsp_count
);

    localparam int ROOT_END = HEADER_BYTES + INFO_BYTES;

    typedef struct packed {
        status_t     status;
        logic [15:0] block_offset;
        logic [15:0] bytes_in_use;
    } rsp_beat_t;

    int          mdl_start [MAX_BLOCKS];
    int          mdl_len [MAX_BLOCKS];
    int          mdl_count;
    int          mdl_usage;
    int          mdl_pool;
    rsp_beat_t   rsp_queue [$];

    function automatic rsp_beat_t predict_alloc(input int req_size);
        rsp_beat_t r;
        int        need;
        int        prev_end;
        int        gap;
        int        pos;
        bit        found;
        need = HEADER_BYTES + req_size;
        prev_end = ROOT_END;
        pos = mdl_count;
        found = 0;
        r.block_offset = '0;
        r.status = STAT_OK;
        if (mdl_pool < mdl_usage + req_size)
            r.status = STAT_NO_ROOM;
        else if (mdl_count >= MAX_BLOCKS)
            r.status = STAT_FULL;
        else
        begin
            for (int i = 0; i < mdl_count; i++)
            begin
                gap = (mdl_start[i] > prev_end) ? mdl_start[i] - prev_end : 0;
                if (gap >= need)
                begin
                    pos = i;
                    found = 1;
                    break;
                end
                prev_end = mdl_start[i] + HEADER_BYTES + mdl_len[i];
            end
            if (!found)
            begin
                gap = (mdl_pool > prev_end) ? mdl_pool - prev_end : 0;
                found = (gap >= need);
            end
            if (!found)
                r.status = STAT_NO_ROOM;
            else
            begin
                for (int i = mdl_count; i > pos; i--)
                begin
                    mdl_start[i] = mdl_start[i-1];
                    mdl_len[i] = mdl_len[i-1];
                end
                mdl_start[pos] = prev_end & 16'hFFFF;
                mdl_len[pos] = req_size;
                mdl_count++;
                mdl_usage = (mdl_usage + need) & 16'hFFFF;
                r.block_offset = 16'(prev_end + HEADER_BYTES);
            end
        end
        r.bytes_in_use = 16'(mdl_usage);
        return r;
    endfunction

    function automatic rsp_beat_t predict_release(input int ofs);
        rsp_beat_t r;
        int        idx;
        int        size;
        idx = -1;
        r.block_offset = '0;
        r.status = STAT_NOT_FOUND;
        for (int i = 0; i < mdl_count; i++)
        begin
            if (mdl_start[i] + HEADER_BYTES == ofs)
            begin
                idx = i;
                break;
            end
        end
        if (idx >= 0)
        begin
            r.status = STAT_OK;
            size = HEADER_BYTES + mdl_len[idx];
            mdl_usage = (mdl_usage > size) ? mdl_usage - size : 0;
            for (int i = idx; i + 1 < mdl_count; i++)
            begin
                mdl_start[i] = mdl_start[i+1];
                mdl_len[i] = mdl_len[i+1];
            end
            mdl_count--;
        end
        r.bytes_in_use = 16'(mdl_usage);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_beat_t e;
        rsp_beat_t got;
        if (!rst_n)
        begin
            mdl_count = 0;
            mdl_usage = ROOT_END;
            mdl_pool = 4096;
            fail_count = 0;
            rsp_count = 0;
            rsp_queue.delete();
            pending = 0;
        end
        else
        begin
            // Check the response first: its beat predates any request taken this edge.
            if (rsp.valid && rsp.ready)
            begin
                got.status = status_t'(rsp.status);
                got.block_offset = rsp.block_offset;
                got.bytes_in_use = rsp.bytes_in_use;
                rsp_count++;
                if (rsp_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected response: status %0d offset %0d usage %0d",
                                 got.status, got.block_offset, got.bytes_in_use);
                end
                else
                begin
                    e = rsp_queue.pop_front();
                    if (e !== got)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: exp st %0d ofs %0d use %0d, ",
                                      "got st %0d ofs %0d use %0d"},
                                     e.status, e.block_offset, e.bytes_in_use,
                                     got.status, got.block_offset, got.bytes_in_use);
                    end
                end
            end
            if (cfg.valid && cfg.ready)
                mdl_pool = cfg.data;
            if (req.valid && req.ready)
            begin
                case (req.operation)
                    OP_ALLOC:   e = predict_alloc(req.request_size);
                    OP_RELEASE: e = predict_release(req.release_offset);
                    OP_FORMAT:
                    begin
                        mdl_count = 0;
                        mdl_usage = ROOT_END;
                        e = '{STAT_OK, 16'd0, 16'(ROOT_END)};
                    end
                    default:    e = '{STAT_OK, 16'd0, 16'(mdl_usage)};
                endcase
                rsp_queue.push_back(e);
            end
            pending = rsp_queue.size();
        end
    end

endmodule

### tb/first_fit_pool_allocator_unit_tb.sv
// Testbench top for the first-fit pool allocator: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module first_fit_pool_allocator_unit_tb;
    import ffpa_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   rsp_count;
    int   ofs_pool [$];
    bit   hold_off;
    bit   fixed_ready;

    ffpa_req_if req ();
    ffpa_rsp_if rsp ();
    ffpa_cfg_if cfg ();

    first_fit_pool_allocator_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    first_fit_pool_allocator_unit_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending),
        .rsp_count  (rsp_count)
    );

    initial clk = 0;
    always #1 clk = ~clk;

    // Track successful allocations so releases mostly hit live blocks.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready && rsp.status == STAT_OK && rsp.block_offset != 0)
            ofs_pool.push_back(rsp.block_offset);
    end

    // Receiver: random stall pattern, always ready when fixed, or a long hold-off when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_off)
            rsp.ready <= 1'b0;
        else if (fixed_ready)
            rsp.ready <= 1'b1;
        else
            rsp.ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_item(input logic [1:0] op, input logic [15:0] size,
                             input logic [15:0] ofs);
        req.valid <= 1'b1;
        req.operation <= op;
        req.request_size <= size;
        req.release_offset <= ofs;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic idle_req(input int cycles);
        req.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_all();
        idle_req(1);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_pool(input logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item();
        int          pick;
        int          k;
        logic [15:0] size;
        logic [15:0] ofs;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            size = 16'($urandom);
        else
            size = 16'($urandom_range(0, 300));
        if (ofs_pool.size() != 0 && $urandom_range(0, 4) != 0)
        begin
            k = $urandom_range(0, ofs_pool.size() - 1);
            ofs = 16'(ofs_pool[k]);
            ofs_pool.delete(k);
        end
        else
            ofs = 16'($urandom);
        if (pick < 55)
            send_item(OP_ALLOC, size, ofs);
        else if (pick < 92)
            send_item(OP_RELEASE, size, ofs);
        else if (pick < 96)
        begin
            send_item(OP_FORMAT, size, ofs);
            ofs_pool.delete();
        end
        else
            send_item(OP_NOP, size, ofs);
    endtask

    task automatic random_phase(input int count);
        int burst;
        int done;
        done = 0;
        while (done < count)
        begin
            burst = $urandom_range(1, 20);
            repeat (burst)
            begin
                random_item();
                done++;
            end
            if ($urandom_range(0, 1) != 0)
                idle_req($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        hold_off = 1'b0;
        fixed_ready = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_ALLOC;
        req.request_size = '0;
        req.release_offset = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (40) @(posedge clk);

        // Directed: default pool, extremes and every operation.
        send_item(OP_ALLOC, 16'd0, 16'd0);
        send_item(OP_ALLOC, 16'hFFFF, 16'd0);
        send_item(OP_ALLOC, 16'd100, 16'd0);
        send_item(OP_RELEASE, 16'd0, 16'd40);
        send_item(OP_RELEASE, 16'd0, 16'hFFFF);
        send_item(OP_RELEASE, 16'd0, 16'd16);
        send_item(OP_NOP, 16'hFFFF, 16'hFFFF);
        send_item(OP_RELEASE, 16'd0, 16'd64);
        send_item(OP_ALLOC, 16'd10, 16'd0);
        // Fill the table to reach table full.
        repeat (18) send_item(OP_ALLOC, 16'd1, 16'd0);
        send_item(OP_FORMAT, 16'd0, 16'd0);
        drain_all();

        // Smallest pool, then shrink below live blocks.
        write_pool(16'd40);
        send_item(OP_ALLOC, 16'd0, 16'd0);
        drain_all();
        write_pool(16'hFFFF);
        send_item(OP_ALLOC, 16'd1000, 16'd0);
        send_item(OP_ALLOC, 16'd500, 16'd0);
        drain_all();
        write_pool(16'd200);
        send_item(OP_ALLOC, 16'd1, 16'd0);
        send_item(OP_FORMAT, 16'd0, 16'd0);
        drain_all();

        ofs_pool.delete();
        write_pool(16'd4096);
        random_phase(150);
        drain_all();
        write_pool(16'd600);
        random_phase(150);
        drain_all();
        write_pool(16'hFFFF);

        // Hold off the receiver while the sender keeps offering beats.
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(20);
        join
        drain_all();

        fixed_ready = 1'b1;
        random_phase(60);
        fixed_ready = 1'b0;
        drain_all();
        write_pool(16'd1500);
        random_phase(200);
        drain_all();

        $display("Covered allocate, release, format and unused codes");
        $display("over pool sizes 40 to 65535, with %0d responses checked under stalls.",
                 rsp_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
src/ffpa_pkg.sv
src/ffpa_if.sv
src/ffpa_cell.sv
src/first_fit_pool_allocator_unit.sv
tb/first_fit_pool_allocator_unit_checker.sv
tb/first_fit_pool_allocator_unit_tb.sv
